FILE: hdl/srsb_pkg.sv
// Shared types and constants of the sprite row slot binner.
package srsb_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_OBJECT = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_CALL   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TOP_ROWS = 2'd0;
  localparam logic [1:0] CFG_RES_ENTRIES = 2'd1;
  localparam logic [1:0] CFG_LAYERS = 2'd2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Most row slices handled for one object
  localparam logic [5:0] MAX_SLICES = 6'd32;

  typedef struct packed {
    logic [1:0]  op;
    logic        visible;
    logic [9:0]  pos_x;
    logic [15:0] pos_y;
    logic [15:0] char_base;
    logic [7:0]  anim_frame;
    logic [15:0] frame_step;
    logic [15:0] phase_step;
    logic [15:0] slice_step;
    logic [7:0]  width_cells;
    logic [5:0]  height_rows;
    logic [7:0]  palette_sel;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  row_index;
    logic [7:0]  slot_index;
    logic [9:0]  gotox_value;
    logic [15:0] first_char;
    logic [7:0]  run_length;
    logic [7:0]  palette_out;
    logic        placed;
    logic [7:0]  drop_total;
    logic        last;
  } out_item_t;

endpackage

FILE: hdl/srsb_mac.sv
// Shared 16-bit multiply-accumulate unit of the character number sequencer.
module srsb_mac (
  input  logic [15:0] acc_i,
  input  logic [15:0] mul_a_i,
  input  logic [7:0]  mul_b_i,
  output logic [15:0] sum_o
);

  logic [23:0] prod;

  assign prod  = {8'd0, mul_a_i} * {16'd0, mul_b_i};
  // keep only the low 16 bits: character numbers wrap
  assign sum_o = acc_i + prod[15:0];

endmodule

FILE: hdl/sprite_row_slot_binner.sv
// Sprite row slot binner: sorts object row slices into per-row display-list slots.
// Start-frame, start-call and empty objects are taken in the accept step alone.
// A visible object holds the input through the accept step, character setup on the shared
// multiply-accumulate unit (S_MUL_A, S_MUL_P), then, for up to min(height_rows, 32) row
// slices, a row count read (S_READ) and a check and write back (S_CHECK). Each result is
// loaded in S_CHECK, which waits while an earlier result is not taken; items never overlap.
// Reset clears control, configuration and drop count; row counts read as zero.
module sprite_row_slot_binner #(
  parameter int unsigned ROWS     = 32,
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned BG_CHARS = 21
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  srsb_pkg::in_item_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output srsb_pkg::out_item_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [srsb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [srsb_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  import srsb_pkg::*;

  localparam int unsigned IdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [7:0] RowsLim   = 8'(ROWS % 256);
  localparam logic [7:0] SlotLimit = 8'(ENTRIES - 2);
  localparam logic [7:0] BgSlots   = 8'((BG_CHARS + 1) % 256);

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL_A = 5'b00010,
    S_MUL_P = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [7:0] top_rows_q;
  logic [5:0] res_entries_q;
  logic [1:0] layers_q;

  // Row count store: entries without a valid bit read as the frame base value
  logic [7:0]      row_mem [ROWS];
  logic [ROWS-1:0] row_valid_q, row_valid_d;
  logic [7:0]      base_q, base_d;
  logic [7:0]      rdata_q;

  logic [7:0] drop_q, drop_d;

  // Current object
  in_item_t   item_q;
  logic [5:0] height_q;
  logic [4:0] slice_q, slice_d;
  logic [15:0] acc_q, acc_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration writes; the sender must issue them only while nothing is in flight, unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_rows_q    <= 8'd0;
      res_entries_q <= 6'd0;
      layers_q      <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOP_ROWS:    top_rows_q    <= cfg_wdata_i;
        CFG_RES_ENTRIES: res_entries_q <= cfg_wdata_i[5:0];
        CFG_LAYERS:      layers_q      <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Shared multiply-accumulate: char_base + frame term, then phase term,
  // then one slice step per slice.
  logic [15:0] mac_acc, mac_a, mac_sum;
  logic [7:0]  mac_b;

  always_comb begin
    mac_acc = acc_q;
    mac_a   = 16'd0;
    mac_b   = 8'd0;
    case (state_q)
      S_MUL_A: begin
        mac_acc = item_q.char_base;
        mac_a   = item_q.frame_step;
        mac_b   = item_q.anim_frame;
      end
      S_MUL_P: begin
        mac_a = item_q.phase_step;
        mac_b = {5'd0, item_q.pos_y[2:0]};
      end
      S_CHECK: begin
        mac_a = item_q.slice_step;
        mac_b = 8'd1;
      end
      default: ;
    endcase
  end

  srsb_mac u_mac (
    .acc_i   (mac_acc),
    .mul_a_i (mac_a),
    .mul_b_i (mac_b),
    .sum_o   (mac_sum)
  );

  // Slice target and fit check
  logic [7:0]      target;
  logic [IdxW-1:0] tidx;
  logic            in_range;
  logic [7:0]      used, limit, new_used;
  logic [9:0]      need;
  logic            fits, is_last, load, mem_we;
  logic [9:0]      init_prod;

  assign target    = item_q.pos_y[10:3] + {3'd0, slice_q};
  assign tidx      = target[IdxW-1:0];
  assign in_range  = (target < RowsLim) || (ROWS > 255);
  assign used      = row_valid_q[tidx] ? rdata_q : base_q;
  assign need      = {2'd0, used} + 10'd1 + {2'd0, item_q.width_cells};
  assign new_used  = need[7:0];
  assign fits      = in_range && (need <= {2'd0, limit});
  assign is_last   = ({1'b0, slice_q} + 6'd1) == height_q;
  assign load      = (state_q == S_CHECK) && (!out_valid_q || out_ready_i);
  assign mem_we    = load && fits;
  assign init_prod = {8'd0, layers_q} * {2'd0, BgSlots};

  always_comb begin
    limit = SlotLimit;
    if (target < top_rows_q) begin
      limit = (SlotLimit > {2'd0, res_entries_q}) ? SlotLimit - {2'd0, res_entries_q} : 8'd0;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    slice_d     = slice_q;
    acc_d       = acc_q;
    drop_d      = drop_q;
    base_d      = base_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.op)
            OP_OBJECT: begin
              if (in_data_i.visible && (in_data_i.height_rows != 6'd0)) begin
                state_d = S_MUL_A;
              end
            end
            OP_FRAME: begin
              // reload every row count at once: drop all valid bits
              base_d      = init_prod[7:0];
              row_valid_d = '0;
            end
            OP_CALL: drop_d = 8'd0;
            default: ;
          endcase
        end
        slice_d = 5'd0;
      end
      S_MUL_A: begin
        acc_d   = mac_sum;
        state_d = S_MUL_P;
      end
      S_MUL_P: begin
        acc_d   = mac_sum;
        state_d = S_READ;
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (load) begin
          if (!fits && (drop_q != 8'hFF)) begin
            drop_d = drop_q + 8'd1;
          end
          if (mem_we) begin
            row_valid_d[tidx] = 1'b1;
          end
          out_valid_d       = 1'b1;
          out_d.row_index   = target;
          out_d.slot_index  = fits ? used : 8'd0;
          out_d.gotox_value = item_q.pos_x;
          out_d.first_char  = acc_q;
          out_d.run_length  = item_q.width_cells;
          out_d.palette_out = item_q.palette_sel;
          out_d.placed      = fits;
          out_d.drop_total  = drop_d;
          out_d.last        = is_last;
          acc_d             = mac_sum;
          slice_d           = slice_q + 5'd1;
          state_d           = is_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slice_q     <= 5'd0;
      drop_q      <= 8'd0;
      base_q      <= 8'd0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slice_q     <= slice_d;
      drop_q      <= drop_d;
      base_q      <= base_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q   <= in_data_i;
      // clamp the slice count to the supported maximum
      height_q <= (in_data_i.height_rows > MAX_SLICES) ? MAX_SLICES : in_data_i.height_rows;
    end
    acc_q <= acc_d;
    out_q <= out_d;
  end

  // Row count memory: one read port (registered), one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rdata_q <= row_mem[tidx];
    end
    if (mem_we) begin
      row_mem[tidx] <= new_used;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A placed slice always fits under the row limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.placed) |->
      ({2'd0, out_data_o.slot_index} + 10'd1 + {2'd0, out_data_o.run_length})
        <= {2'd0, SlotLimit})
    else $error("placed slice exceeds slot limit");

  // A placed slice targets a row inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.placed) |-> (out_data_o.row_index < RowsLim || ROWS > 255))
    else $error("placed slice outside row table");

  // Drop count only falls after a start-call transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop_q < $past(drop_q)) |->
      $past(in_acc && (in_data_i.op == OP_CALL)))
    else $error("drop count fell without start call");

  // A new result is only loaded from the slice check step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_CHECK))
    else $error("result loaded outside slice check");
`endif

endmodule

FILE: tb/tb_sprite_row_slot_binner.sv
// Self-checking testbench of the sprite row slot binner: directed, config sweep, random.
module tb_sprite_row_slot_binner;
  timeunit 1ns;
  timeprecision 1ps;

  import srsb_pkg::*;

  // Block parameters, kept equal to the instance below
  localparam int unsigned ROWS     = 32;
  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned BG_CHARS = 21;

  // The fourth op code has no name in the package; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CLK_HALF      = 5;
  // Control items and empty objects finish in their accept step
  localparam int unsigned SETTLE_CYCLES = 4;
  // Longest object: setup steps plus a read and a check per slice, with margin
  localparam int unsigned DRAIN_CYCLES  = 2 + 2 * 32 + 14;
  // Timeout of the whole run, in nanoseconds
  localparam int unsigned TIMEOUT_NS    = 8_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow of the block: configuration, per-row slot fill and drop tally
  logic [7:0] top_rows_cfg;
  logic [5:0] reserve_cfg;
  logic [1:0] layers_cfg;
  logic [7:0] row_fill [ROWS];
  logic [7:0] drops_seen;

  // Slice descriptors predicted but not yet seen on the output
  out_item_t  slices_due [$];
  out_item_t  want;
  int unsigned mismatches;

  // Set to suppress all random idling on both sides
  bit no_gaps;

  sprite_row_slot_binner #(
    .ROWS     (ROWS),
    .ENTRIES  (ENTRIES),
    .BG_CHARS (BG_CHARS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  // Work out the slice descriptors one accepted transaction produces and
  // advance the shadow state the same way the block does.
  function automatic void predict_slices(in_item_t it);
    logic [7:0]  row0;
    logic [7:0]  target;
    logic [7:0]  slot;
    logic [15:0] ch;
    int unsigned depth;
    int unsigned limit;
    int unsigned used;
    int unsigned s;
    bit          fits;
    out_item_t   res;
    case (it.op)
      OP_FRAME: begin
        // Reload every row with the slots the background layers take
        foreach (row_fill[r]) row_fill[r] = 8'(layers_cfg * (BG_CHARS + 1));
      end
      OP_CALL: begin
        drops_seen = '0;
      end
      OP_OBJECT: begin
        if (it.visible) begin
          row0  = it.pos_y[10:3];
          ch    = 16'(it.char_base + it.anim_frame * it.frame_step
                      + it.pos_y[2:0] * it.phase_step);
          depth = (it.height_rows > MAX_SLICES) ? MAX_SLICES : it.height_rows;
          for (s = 0; s < depth; s++) begin
            target = 8'(row0 + s);
            limit  = ENTRIES - 2;
            // Top rows give up the reserved entries, never below zero
            if (target < top_rows_cfg)
              limit = (limit > reserve_cfg) ? limit - reserve_cfg : 0;
            fits = 1'b0;
            slot = '0;
            if (target < ROWS) begin
              used = row_fill[target];
              if (used + 1 + it.width_cells <= limit) begin
                fits = 1'b1;
                slot = 8'(used);
                row_fill[target] = 8'(used + it.width_cells + 1);
              end
            end
            // Drop tally saturates
            if (!fits && drops_seen != 8'hFF) drops_seen++;
            res.row_index   = target;
            res.slot_index  = slot;
            res.gotox_value = it.pos_x;
            res.first_char  = ch;
            res.run_length  = it.width_cells;
            res.palette_out = it.palette_sel;
            res.placed      = fits;
            res.drop_total  = drops_seen;
            res.last        = (s + 1 == depth);
            slices_due.push_back(res);
            ch = ch + it.slice_step;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t control_item(logic [1:0] op);
    in_item_t it;
    it    = '0;
    it.op = op;
    return it;
  endfunction

  function automatic in_item_t plain_object();
    in_item_t it;
    it             = '0;
    it.op          = OP_OBJECT;
    it.visible     = 1'b1;
    it.height_rows = 6'd1;
    return it;
  endfunction

  // Mostly well-formed objects landing on table rows with narrow runs, so
  // rows fill up over a frame; the rest is frame/call markers and noise.
  function automatic in_item_t random_item();
    in_item_t     it;
    logic [159:0] raw;
    int unsigned  pick;
    raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it   = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick >= 94) return it;
    if (pick >= 88) begin
      it.op = OP_CALL;
      return it;
    end
    if (pick >= 82) begin
      it.op = OP_FRAME;
      return it;
    end
    it.op      = OP_OBJECT;
    it.visible = (pick < 76);
    if ($urandom_range(0, 9) != 0) it.pos_y = 16'($urandom_range(0, ROWS * 8 - 1));
    it.width_cells = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 16))
                                                 : 8'($urandom_range(17, 255));
    it.height_rows = ($urandom_range(0, 6) != 0) ? 6'($urandom_range(1, 6))
                                                 : 6'($urandom_range(7, 63));
    return it;
  endfunction

  // Present one transaction after a random gap and hold it until accepted.
  // Entered and left at a falling edge where in_valid_i has not been driven yet.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_slices(it);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every predicted slice has arrived, then let
  // the block settle for the given number of cycles.
  task automatic wait_idle(int unsigned cycles);
    in_valid_i <= 1'b0;
    while (slices_due.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  // Write all three registers in back-to-back cycles; raw data keeps the
  // upper bits so the field masking is exercised too.
  task automatic set_config(logic [7:0] top, logic [7:0] res, logic [7:0] layers);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TOP_ROWS;
    cfg_wdata_i <= top;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RES_ENTRIES;
    cfg_wdata_i <= res;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_LAYERS;
    cfg_wdata_i <= layers;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    top_rows_cfg = top;
    reserve_cfg  = res[5:0];
    layers_cfg   = layers[1:0];
  endtask

  task automatic compare_field(string label, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch at %0t: expected %0d got %0d", label, $realtime, want_v, got_v);
    end
  endtask

  // Field extremes, every op, clamped height, dropped and off-table slices,
  // exact-fit boundary, character arithmetic wrap and drop saturation.
  task automatic test_directed();
    in_item_t it;
    send_item(control_item(OP_FRAME));
    send_item(plain_object());
    // All ones: row 255 wraps into the table, height clamps, nothing fits
    it    = '1;
    it.op = OP_OBJECT;
    send_item(it);
    it.visible = 1'b0;
    send_item(it);
    it = plain_object();
    it.height_rows = 6'd0;
    it.width_cells = 8'd3;
    send_item(it);
    it    = '1;
    it.op = OP_UNUSED;
    send_item(it);
    send_item(control_item(OP_CALL));
    // First slices below the table
    it = plain_object();
    it.pos_y       = 16'(ROWS * 8);
    it.width_cells = 8'd1;
    it.height_rows = 6'd2;
    send_item(it);
    // Fill row 1 exactly to the limit, then overflow it
    it = plain_object();
    it.pos_y       = 16'd8;
    it.width_cells = 8'd60;
    send_item(it);
    it.width_cells = 8'd0;
    send_item(it);
    send_item(it);
    it.pos_y       = 16'd16;
    it.width_cells = 8'd61;
    send_item(it);
    it.pos_y       = 16'd24;
    it.width_cells = 8'd62;
    send_item(it);
    // Fine phase 7 with wrapping character sums
    it = plain_object();
    it.pos_x       = 10'h2AA;
    it.pos_y       = 16'(5 * 8 + 7);
    it.char_base   = 16'hFFF0;
    it.anim_frame  = 8'h81;
    it.frame_step  = 16'h1235;
    it.phase_step  = 16'h8001;
    it.slice_step  = 16'hFFFF;
    it.width_cells = 8'd2;
    it.height_rows = 6'd3;
    it.palette_sel = 8'h5A;
    send_item(it);
    // Push the drop tally past its ceiling
    repeat (8) begin
      it = plain_object();
      it.pos_x       = 10'($urandom);
      it.width_cells = 8'd255;
      it.height_rows = 6'd32;
      send_item(it);
    end
    send_item(control_item(OP_FRAME));
  endtask

  // Walk through register settings, extremes included, each followed by a
  // frame reload, a start call and three random items.
  task automatic test_config_sweep();
    logic [7:0] tops   [6] = '{8'd0, 8'd255, 8'd16, 8'd255, 8'd0,  8'h80};
    logic [7:0] resv   [6] = '{8'd0, 8'd62,  8'd10, 8'hFF,  8'd33, 8'hC5};
    logic [7:0] layers [6] = '{8'd0, 8'd2,   8'd1,  8'd3,   8'd2,  8'hFE};
    for (int k = 0; k < 6; k++) begin
      wait_idle(SETTLE_CYCLES);
      set_config(tops[k], resv[k], layers[k]);
      send_item(control_item(OP_FRAME));
      send_item(control_item(OP_CALL));
      repeat (3) send_item(random_item());
    end
  endtask

  // Random phases, each with its own setting; one phase runs with no idling
  // and some phases pause the sender until the output side has caught up.
  task automatic test_random_traffic();
    logic [7:0] top;
    logic [7:0] res;
    logic [7:0] lay;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle(SETTLE_CYCLES);
      top = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, ROWS + 4));
      res = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 24));
      lay = ($urandom_range(0, 9) == 0) ? 8'd3 : 8'($urandom_range(0, 2));
      set_config(top, res, lay);
      no_gaps = (ph == 3);
      send_item(control_item(OP_FRAME));
      send_item(control_item(OP_CALL));
      for (int n = 0; n < 36; n++) begin
        if (n == 20 && (ph == 0 || $urandom_range(0, 3) == 0)) wait_idle(SETTLE_CYCLES);
        send_item(random_item());
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: stall a random number of cycles before taking each
  // transaction, then hold ready until one is taken.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Compare every taken transaction with the oldest predicted slice
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (slices_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected slice at %0t: row %0d slot %0d char %0h placed %0d",
                   $realtime, out_data_o.row_index, out_data_o.slot_index,
                   out_data_o.first_char, out_data_o.placed);
      end else begin
        want = slices_due.pop_front();
        compare_field("row_index",   want.row_index,   out_data_o.row_index);
        compare_field("slot_index",  want.slot_index,  out_data_o.slot_index);
        compare_field("gotox_value", want.gotox_value, out_data_o.gotox_value);
        compare_field("first_char",  want.first_char,  out_data_o.first_char);
        compare_field("run_length",  want.run_length,  out_data_o.run_length);
        compare_field("palette_out", want.palette_out, out_data_o.palette_out);
        compare_field("placed",      want.placed,      out_data_o.placed);
        compare_field("drop_total",  want.drop_total,  out_data_o.drop_total);
        compare_field("last",        want.last,        out_data_o.last);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_sprite_row_slot_binner failed");
    $finish;
  end

  initial begin
    // Drive every input to a known value and clear the shadow state
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TOP_ROWS;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    no_gaps      = 1'b0;
    mismatches   = 0;
    top_rows_cfg = '0;
    reserve_cfg  = '0;
    layers_cfg   = '0;
    drops_seen   = '0;
    foreach (row_fill[r]) row_fill[r] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_config_sweep();
    test_random_traffic();

    // Drain, then watch a while longer for stray results
    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0 && slices_due.size() == 0) begin
      $display("tb_sprite_row_slot_binner passed");
    end else begin
      $display("tb_sprite_row_slot_binner failed");
    end
    $finish;
  end

endmodule
